// File: rtl/assert_macros.svh
// Assertion macros used by the RTL module.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/drdc_pkg.sv
// Shared types and constants of the docking-ring drive controller.
// Depends on nothing; used by the top level.
package drdc_pkg;

    localparam int POS_W  = 17;
    localparam int STEP_W = 13;

    localparam logic [POS_W-1:0] POS_FULL       = 17'd65536;
    localparam logic [POS_W-1:0] TH_GOAL_INIT   = 17'd47378;
    localparam logic [POS_W-1:0] TH_STOP_INIT   = 17'd48242;
    localparam logic [POS_W-1:0] TH_FINAL_LIGHT = 17'd4142;
    localparam logic [POS_W-1:0] TH_INIT_HIGH   = 17'd49107;
    localparam logic [POS_W-1:0] TH_FORWARD     = 17'd64672;

    localparam logic [STEP_W-1:0] RING_STEP_RESET = 13'd5;

    // Register index of the only configuration register.
    localparam logic REG_RING_STEP = 1'b0;

    // Reported motion codes.
    localparam logic [1:0] MOTION_CODE_STOPPED = 2'd0;
    localparam logic [1:0] MOTION_CODE_OPENING = 2'd1;
    localparam logic [1:0] MOTION_CODE_CLOSING = 2'd2;

    typedef enum logic [2:0] {
        MOT_STOPPED = 3'b001,
        MOT_OPENING = 3'b010,
        MOT_CLOSING = 3'b100
    } motion_t;

    typedef enum logic [1:0] {
        GOAL_RETRACT_FINAL = 2'd0,
        GOAL_EXTEND_INIT   = 2'd1,
        GOAL_EXTEND_FINAL  = 2'd2
    } goal_t;

endpackage

// File: rtl/docking_ring_drive_controller.sv
// Docking-ring drive controller: command register, one tick of control
// logic and a result register. Depends on drdc_pkg and assert_macros.svh.
//
// Usage:
// - Input channel s_*: one item per control tick with the six panel commands.
// - Result channel m_*: one item per input item with the seven lights, the
//   ring position (Q1.16, 65536 is full travel) and the motion code.
// - APB port: register 0 (byte address 0) holds ring_step, the position
//   increment per tick. Write it only while no item is in flight.
// An accepted item waits in the command register and its result is loaded into
// the result register when that register advances. One item is accepted per
// cycle while the receiver does not stall; the rate is set by the single update
// of the control state between the command register and the result register.
// When the receiver stalls, the result register holds and the command
// register fills; the input side then stalls too, no item is lost.
// Reset clears both valid bits, switches the relay off, protection on,
// fixers on, the ring stopped at position 0, and loads ring_step with 5.
`include "assert_macros.svh"

module docking_ring_drive_controller
    import drdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_power_on,
    input  logic        s_power_off,
    input  logic        s_ring_out,
    input  logic        s_ring_in,
    input  logic        s_circ_prot_off_cmd,
    input  logic        s_fixer_off_cmd,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_power_light,
    output logic        m_ring_aligned_light,
    output logic        m_circ_prot_light,
    output logic        m_fixers_off_light,
    output logic        m_ring_final_light,
    output logic        m_ring_initial_light,
    output logic        m_ring_forward_light,
    output logic [16:0] m_ring_position,
    output logic [1:0]  m_ring_motion,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration.
    logic [STEP_W-1:0] ring_step_reg;

    // Command register.
    logic in_valid_reg;
    logic power_on_reg, power_off_reg, ring_out_reg, ring_in_reg;
    logic circ_prot_off_cmd_reg, fixer_off_cmd_reg;

    // Control state.
    logic              relay_reg, relay_next;
    logic              prot_off_reg, prot_off_next;
    logic              fixers_on_reg, fixers_on_next;
    motion_t           motion_reg, motion_next;
    goal_t             goal_reg, goal_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    // Result register.
    logic              out_valid_reg;
    logic              l_pwr_reg, l_align_reg, l_cp_reg, l_fx_reg;
    logic              l_final_reg, l_init_reg, l_fwd_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [1:0]        out_motion_reg;

    logic              l_cp_next, l_fx_next, l_final_next, l_init_next, l_fwd_next;
    logic [1:0]        motion_code_next;
    logic [POS_W:0]    pos_sum;
    logic [POS_W-1:0]  step_ext;
    logic              advance;
    logic              cfg_write;
    logic              flag_lights_dark;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_RING_STEP)
                     ? {{(32-STEP_W){1'b0}}, ring_step_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_step_reg <= RING_STEP_RESET;
        end else if (cfg_write && paddr[2] == REG_RING_STEP) begin
            ring_step_reg <= pwdata[STEP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            power_on_reg          <= s_power_on;
            power_off_reg         <= s_power_off;
            ring_out_reg          <= s_ring_out;
            ring_in_reg           <= s_ring_in;
            circ_prot_off_cmd_reg <= s_circ_prot_off_cmd;
            fixer_off_cmd_reg     <= s_fixer_off_cmd;
        end
    end

    assign step_ext = {{(POS_W-STEP_W){1'b0}}, ring_step_reg};

    // One control tick, applied in command order.
    always_comb begin
        relay_next     = relay_reg;
        prot_off_next  = prot_off_reg;
        fixers_on_next = fixers_on_reg;
        motion_next    = motion_reg;
        goal_next      = goal_reg;
        pos_next       = pos_reg;
        l_cp_next      = 1'b0;
        l_fx_next      = 1'b0;
        l_final_next   = 1'b0;
        l_init_next    = 1'b0;
        l_fwd_next     = 1'b0;
        pos_sum        = {1'b0, pos_reg} + {1'b0, step_ext};

        if (power_on_reg) begin
            relay_next    = 1'b1;
            prot_off_next = 1'b0;
        end
        if (power_off_reg) begin
            relay_next = 1'b0;
        end

        if (relay_next) begin
            if (circ_prot_off_cmd_reg) begin
                prot_off_next = 1'b1;
            end
            if (fixer_off_cmd_reg) begin
                fixers_on_next = 1'b0;
            end
            l_cp_next = prot_off_next;
            l_fx_next = !fixers_on_next;

            if (ring_out_reg && prot_off_next) begin
                motion_next    = MOT_OPENING;
                goal_next      = (pos_reg >= TH_GOAL_INIT) ? GOAL_EXTEND_FINAL
                                                           : GOAL_EXTEND_INIT;
                fixers_on_next = 1'b1;
            end
            if (ring_in_reg && prot_off_next) begin
                motion_next    = MOT_CLOSING;
                goal_next      = GOAL_RETRACT_FINAL;
                fixers_on_next = 1'b1;
            end

            // Opening saturates at full travel, closing at zero.
            if (motion_next == MOT_OPENING) begin
                pos_next = (pos_sum > {1'b0, POS_FULL}) ? POS_FULL : pos_sum[POS_W-1:0];
            end else if (motion_next == MOT_CLOSING) begin
                pos_next = (pos_reg > step_ext) ? pos_reg - step_ext : '0;
            end

            if (motion_next != MOT_STOPPED) begin
                if (pos_next >= TH_STOP_INIT && goal_next == GOAL_EXTEND_INIT) begin
                    motion_next = MOT_STOPPED;
                end
                if (pos_next >= POS_FULL && goal_next == GOAL_EXTEND_FINAL) begin
                    motion_next = MOT_STOPPED;
                end
            end

            l_final_next = pos_next < TH_FINAL_LIGHT;
            l_init_next  = (pos_next >= TH_GOAL_INIT) && (pos_next < TH_INIT_HIGH);
            l_fwd_next   = pos_next >= TH_FORWARD;
        end

        unique case (motion_next)
            MOT_OPENING: motion_code_next = MOTION_CODE_OPENING;
            MOT_CLOSING: motion_code_next = MOTION_CODE_CLOSING;
            default:     motion_code_next = MOTION_CODE_STOPPED;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_reg     <= 1'b0;
            prot_off_reg  <= 1'b0;
            fixers_on_reg <= 1'b1;
            motion_reg    <= MOT_STOPPED;
            goal_reg      <= GOAL_RETRACT_FINAL;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                relay_reg     <= relay_next;
                prot_off_reg  <= prot_off_next;
                fixers_on_reg <= fixers_on_next;
                motion_reg    <= motion_next;
                goal_reg      <= goal_next;
                pos_reg       <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            l_pwr_reg      <= relay_next;
            l_align_reg    <= relay_next;
            l_cp_reg       <= l_cp_next;
            l_fx_reg       <= l_fx_next;
            l_final_reg    <= l_final_next;
            l_init_reg     <= l_init_next;
            l_fwd_reg      <= l_fwd_next;
            out_pos_reg    <= pos_next;
            out_motion_reg <= motion_code_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_power_light        = l_pwr_reg;
    assign m_ring_aligned_light = l_align_reg;
    assign m_circ_prot_light    = l_cp_reg;
    assign m_fixers_off_light   = l_fx_reg;
    assign m_ring_final_light   = l_final_reg;
    assign m_ring_initial_light = l_init_reg;
    assign m_ring_forward_light = l_fwd_reg;
    assign m_ring_position      = out_pos_reg;
    assign m_ring_motion        = out_motion_reg;

    assign flag_lights_dark = !m_circ_prot_light && !m_fixers_off_light && !m_ring_final_light
                            && !m_ring_initial_light && !m_ring_forward_light;

    `ASSERT_ALWAYS(a_pos_in_range, aclk, aresetn, pos_reg <= POS_FULL)
    `ASSERT_ALWAYS(a_motion_onehot, aclk, aresetn, $onehot(motion_reg))
    `ASSERT_IMPLIES(a_dark_when_off, aclk, aresetn, m_valid && !m_power_light, flag_lights_dark)
    `ASSERT_IMPLIES(a_result_pos, aclk, aresetn, m_valid && !in_valid_reg, out_pos_reg == pos_reg)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the docking-ring drive controller.
// Depends on drdc_pkg and the docking_ring_drive_controller RTL only.
module tb_top
    import drdc_pkg::*;
();

    localparam int QUIET_LIMIT  = 1000;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic power_on;
        logic power_off;
        logic ring_out;
        logic ring_in;
        logic prot_off_cmd;
        logic fixer_off_cmd;
    } panel_cmd_t;

    typedef struct packed {
        logic        power_light;
        logic        aligned_light;
        logic        prot_light;
        logic        fixers_light;
        logic        final_light;
        logic        initial_light;
        logic        forward_light;
        logic [16:0] position;
        logic [1:0]  motion;
    } ring_readout_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_power_on = 1'b0;
    logic        s_power_off = 1'b0;
    logic        s_ring_out = 1'b0;
    logic        s_ring_in = 1'b0;
    logic        s_circ_prot_off_cmd = 1'b0;
    logic        s_fixer_off_cmd = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_power_light;
    logic        m_ring_aligned_light;
    logic        m_circ_prot_light;
    logic        m_fixers_off_light;
    logic        m_ring_final_light;
    logic        m_ring_initial_light;
    logic        m_ring_forward_light;
    logic [16:0] m_ring_position;
    logic [1:0]  m_ring_motion;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    docking_ring_drive_controller u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow of the controller state, advanced once per accepted item.
    logic              relay_on;
    logic              prot_off;
    logic              fixers_engaged;
    logic [1:0]        motion_code;
    goal_t             ext_goal;
    logic [POS_W-1:0]  ring_pos;
    logic [STEP_W-1:0] ring_step_cfg;

    ring_readout_t pending_readouts[$];

    int       errors = 0;
    int       ticks_sent = 0;
    int       powered_ticks = 0;
    int       readouts_checked = 0;
    int       full_travel_hits = 0;
    int       retracted_hits = 0;
    int       step_settings = 0;
    int       burst_left = 0;
    bit       tx_idle = 1'b0;
    rx_mode_t rx_mode = RX_ALWAYS;
    logic [15:0] rx_pat = 16'hA5F1;
    logic [5:0]  rx_phase = 6'd0;
    int       quiet_cycles = 0;

    function automatic void reset_shadow();
        relay_on = 1'b0;
        prot_off = 1'b0;
        fixers_engaged = 1'b1;
        motion_code = MOTION_CODE_STOPPED;
        ext_goal = GOAL_RETRACT_FINAL;
        ring_pos = '0;
        ring_step_cfg = RING_STEP_RESET;
    endfunction

    // One control tick: power commands first, then flags, ring commands,
    // motion with its stops, and finally the position bands.
    function automatic ring_readout_t drive_tick(input panel_cmd_t c);
        ring_readout_t r;
        logic [17:0]   sum;
        r = '0;
        if (c.power_on) begin
            relay_on = 1'b1;
            prot_off = 1'b0;
        end
        if (c.power_off)
            relay_on = 1'b0;
        if (relay_on) begin
            powered_ticks++;
            r.power_light = 1'b1;
            r.aligned_light = 1'b1;
            if (c.prot_off_cmd)
                prot_off = 1'b1;
            if (c.fixer_off_cmd)
                fixers_engaged = 1'b0;
            // Both flag lights are taken before a ring command re-engages the fixers.
            r.prot_light = prot_off;
            r.fixers_light = !fixers_engaged;
            if (c.ring_out && prot_off) begin
                motion_code = MOTION_CODE_OPENING;
                ext_goal = (ring_pos >= TH_GOAL_INIT) ? GOAL_EXTEND_FINAL : GOAL_EXTEND_INIT;
                fixers_engaged = 1'b1;
            end
            if (c.ring_in && prot_off) begin
                motion_code = MOTION_CODE_CLOSING;
                ext_goal = GOAL_RETRACT_FINAL;
                fixers_engaged = 1'b1;
            end
            if (motion_code == MOTION_CODE_OPENING) begin
                sum = 18'(ring_pos) + 18'(ring_step_cfg);
                ring_pos = (sum > 18'(POS_FULL)) ? POS_FULL : sum[16:0];
                if (ring_pos == POS_FULL)
                    full_travel_hits++;
            end else if (motion_code == MOTION_CODE_CLOSING) begin
                ring_pos = (ring_pos > 17'(ring_step_cfg)) ? ring_pos - 17'(ring_step_cfg) : '0;
                if (ring_pos == '0)
                    retracted_hits++;
            end
            if (motion_code == MOTION_CODE_OPENING || motion_code == MOTION_CODE_CLOSING) begin
                if (ring_pos >= TH_STOP_INIT && ext_goal == GOAL_EXTEND_INIT)
                    motion_code = MOTION_CODE_STOPPED;
                if (ring_pos >= POS_FULL && ext_goal == GOAL_EXTEND_FINAL)
                    motion_code = MOTION_CODE_STOPPED;
            end
            r.final_light = (ring_pos < TH_FINAL_LIGHT);
            r.initial_light = (ring_pos >= TH_GOAL_INIT && ring_pos < TH_INIT_HIGH);
            r.forward_light = (ring_pos >= TH_FORWARD);
        end
        r.position = ring_pos;
        r.motion = motion_code;
        return r;
    endfunction

    task automatic log_error(input string msg);
        if (errors < MAX_REPORTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            log_error($sformatf("readout %0d field %s: expected %0d, got %0d",
                                readouts_checked, name, want, got));
    endtask

    // Results are checked before the item accepted at the same edge is predicted.
    always @(posedge aclk) begin : readout_check
        ring_readout_t want;
        ring_readout_t got;
        panel_cmd_t    cmd;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_power_light, m_ring_aligned_light, m_circ_prot_light,
                       m_fixers_off_light, m_ring_final_light, m_ring_initial_light,
                       m_ring_forward_light, m_ring_position, m_ring_motion};
                if (pending_readouts.size() == 0) begin
                    log_error("readout arrived with nothing pending");
                end else begin
                    want = pending_readouts.pop_front();
                    if (^got === 1'bx)
                        log_error($sformatf("readout %0d has unknown bits", readouts_checked));
                    check_field("power_light", int'(want.power_light),
                                int'(got.power_light));
                    check_field("ring_aligned_light", int'(want.aligned_light),
                                int'(got.aligned_light));
                    check_field("circ_prot_light", int'(want.prot_light),
                                int'(got.prot_light));
                    check_field("fixers_off_light", int'(want.fixers_light),
                                int'(got.fixers_light));
                    check_field("ring_final_light", int'(want.final_light),
                                int'(got.final_light));
                    check_field("ring_initial_light", int'(want.initial_light),
                                int'(got.initial_light));
                    check_field("ring_forward_light", int'(want.forward_light),
                                int'(got.forward_light));
                    check_field("ring_position", int'(want.position),
                                int'(got.position));
                    check_field("ring_motion", int'(want.motion),
                                int'(got.motion));
                end
                readouts_checked++;
            end
            if (s_valid && s_ready) begin
                cmd = {s_power_on, s_power_off, s_ring_out, s_ring_in,
                       s_circ_prot_off_cmd, s_fixer_off_cmd};
                pending_readouts.push_back(drive_tick(cmd));
            end
        end
    end

    // Receiver: always ready, random stalls, or a rotating 16-bit pattern that is
    // reloaded with a random value each time the 6-bit phase counter wraps.
    always @(posedge aclk) begin
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= rx_pat[0];
        endcase
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == 6'h3F)
            rx_pat <= 16'($urandom) | 16'h0001;
        else
            rx_pat <= {rx_pat[0], rx_pat[15:1]};
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic panel_cmd_t cmd_of(input bit pon, input bit poff, input bit rout,
                                          input bit rin, input bit cp, input bit fx);
        return {pon, poff, rout, rin, cp, fx};
    endfunction

    // Sends one panel tick; the sender idles between bursts when enabled.
    task automatic send_panel_tick(input panel_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = tx_idle ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_power_on <= c.power_on;
        s_power_off <= c.power_off;
        s_ring_out <= c.ring_out;
        s_ring_in <= c.ring_in;
        s_circ_prot_off_cmd <= c.prot_off_cmd;
        s_fixer_off_cmd <= c.fixer_off_cmd;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Holds the sender until every pending readout has been checked.
    task automatic wait_readouts_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_readouts.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic check_ring_step_reg(input logic [STEP_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'(4 * REG_RING_STEP);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 32'(want))
            log_error($sformatf("ring_step readback: expected %0d, got %0d", want, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_ring_step(input logic [STEP_W-1:0] value);
        wait_readouts_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_RING_STEP);
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        ring_step_cfg = value;
        step_settings++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        check_ring_step_reg(value);
        @(posedge aclk);
    endtask

    // Mostly well-formed panel use: power up, switch protection off, then
    // ring commands among quiet ticks. One tick in ten is random noise.
    function automatic panel_cmd_t pick_panel_cmd();
        panel_cmd_t c;
        c = '0;
        if ($urandom_range(0, 9) == 0) begin
            c = panel_cmd_t'(6'($urandom_range(0, 63)));
        end else if (!relay_on) begin
            c.power_on = ($urandom_range(0, 9) < 7);
        end else if (!prot_off) begin
            c.prot_off_cmd = ($urandom_range(0, 1) == 1);
            c.fixer_off_cmd = ($urandom_range(0, 9) == 0);
        end else begin
            c.ring_out = ($urandom_range(0, 99) < 12);
            c.ring_in = ($urandom_range(0, 99) < 8);
            c.fixer_off_cmd = ($urandom_range(0, 99) < 8);
            c.prot_off_cmd = ($urandom_range(0, 99) < 5);
            c.power_on = ($urandom_range(0, 99) < 3);
            c.power_off = ($urandom_range(0, 99) < 2);
        end
        return c;
    endfunction

    task automatic run_random_phase(input logic [STEP_W-1:0] step, input int n,
                                    input bit idle_tx, input rx_mode_t rx);
        int target;
        set_ring_step(step);
        tx_idle = idle_tx;
        rx_mode = rx;
        target = powered_ticks + n;
        while (powered_ticks < target)
            send_panel_tick(pick_panel_cmd());
    endtask

    task automatic test_unpowered();
        check_ring_step_reg(RING_STEP_RESET);
        send_panel_tick(cmd_of(0, 0, 0, 0, 0, 0));
        send_panel_tick(cmd_of(0, 0, 1, 1, 1, 1));
        // Both power commands at once: off wins.
        send_panel_tick(cmd_of(1, 1, 1, 0, 1, 1));
    endtask

    task automatic test_power_and_flags();
        send_panel_tick(cmd_of(1, 0, 0, 0, 0, 0));
        // Ring command with protection still on is ignored.
        send_panel_tick(cmd_of(0, 0, 1, 0, 0, 0));
        send_panel_tick(cmd_of(0, 0, 0, 0, 1, 1));
        // Ring in beats ring out; retraction from zero saturates.
        send_panel_tick(cmd_of(0, 0, 1, 1, 0, 0));
        send_panel_tick(cmd_of(0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_travel_limits();
        set_ring_step(13'h1FFF);
        send_panel_tick(cmd_of(0, 0, 1, 0, 0, 0));
        repeat (5) send_panel_tick(cmd_of(0, 0, 0, 0, 0, 0));
        // Past the initial band the goal becomes full travel, which saturates.
        send_panel_tick(cmd_of(0, 0, 1, 0, 0, 0));
        repeat (2) send_panel_tick(cmd_of(0, 0, 0, 0, 0, 0));
        send_panel_tick(cmd_of(0, 0, 1, 0, 0, 0));
        // Power on again restores protection, so the ring command is ignored.
        send_panel_tick(cmd_of(1, 0, 0, 1, 0, 0));
    endtask

    task automatic test_zero_step();
        set_ring_step('0);
        send_panel_tick(cmd_of(0, 0, 0, 0, 1, 0));
        send_panel_tick(cmd_of(0, 0, 0, 1, 0, 0));
        send_panel_tick(cmd_of(0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_drive();
        run_random_phase(13'($urandom_range(1500, 4096)), 110, 1'b1, RX_RANDOM);
        run_random_phase(13'h1FFF, 80, 1'b0, RX_ALWAYS);
        run_random_phase(13'd1, 50, 1'b1, RX_PATTERN);
        run_random_phase(13'd4096, 100, 1'b0, RX_PATTERN);
        run_random_phase(13'($urandom_range(1, 8191)), 100, 1'b1, RX_RANDOM);
        run_random_phase('0, 30, 1'b1, RX_ALWAYS);
        run_random_phase(13'($urandom_range(200, 3000)), 100, 1'b1, RX_PATTERN);
    endtask

    initial begin
        reset_shadow();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_unpowered();
        test_power_and_flags();
        test_travel_limits();
        test_zero_step();
        test_random_drive();
        wait_readouts_drained();
        repeat (6) @(posedge aclk);
        if (pending_readouts.size() != 0)
            log_error("readouts still pending at the end");
        $display("Sent %0d panel ticks (%0d powered), checked %0d readouts.",
                 ticks_sent, powered_ticks, readouts_checked);
        $display("Ring hit full travel %0d times and zero %0d times across %0d step values.",
                 full_travel_hits, retracted_hits, step_settings);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/drdc_pkg.sv
rtl/docking_ring_drive_controller.sv
tb/tb_top.sv
